>>> rtl/phsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phsr_pkg: shared definitions for the packet header strip and restore core
// Holds field widths, register indexes, result codes and the configuration
// bundle that passes from the register file to the byte engine.
// ----------------------------------------------------------------------------
package phsr_pkg;

  localparam int MAX_HEADER_BYTES_DEF = 8;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 4;
  localparam int HDR_W    = 64;
  localparam int SLOTS    = HDR_W / BYTE_W;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CFG_IX_W = 2;
  localparam int ERR_W    = 2;

  // Configuration register indexes.
  localparam logic [CFG_IX_W-1:0] REG_DIRECTION     = 2'd0;
  localparam logic [CFG_IX_W-1:0] REG_HEADER_LENGTH = 2'd1;
  localparam logic [CFG_IX_W-1:0] REG_HEADER_BYTES  = 2'd2;

  // Direction codes.
  localparam logic DIR_STRIP   = 1'b0;
  localparam logic DIR_RESTORE = 1'b1;

  // Result error codes.
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_SHORT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_MISMATCH  = 2'd2;

  typedef struct packed {
    logic             direction;
    logic [LEN_W-1:0] length;    // already clamped to the header bound
    logic [HDR_W-1:0] header;
  } cfg_t;

endpackage : phsr_pkg
`default_nettype wire

>>> rtl/phsr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phsr_cfg: configuration register file
// Decodes register writes and presents the header length clamped to the bound.
// ----------------------------------------------------------------------------
module phsr_cfg #(
  parameter int MAX_HEADER_BYTES = phsr_pkg::MAX_HEADER_BYTES_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_valid,
  input  wire  [phsr_pkg::CFG_IX_W-1:0]   cfg_index,
  input  wire  [phsr_pkg::HDR_W-1:0]      cfg_data,
  output phsr_pkg::cfg_t                  cfg
);
  import phsr_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_HEADER_BYTES);

  logic             direction;
  logic [LEN_W-1:0] header_length;
  logic [HDR_W-1:0] header_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= DIR_STRIP;
      header_length <= '0;
      header_bytes  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIRECTION:     direction     <= cfg_data[0];
        REG_HEADER_LENGTH: header_length <= cfg_data[LEN_W-1:0];
        REG_HEADER_BYTES:  header_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.direction = direction;
    cfg.length    = (header_length > MAX_LEN) ? MAX_LEN : header_length;
    cfg.header    = header_bytes;
  end

endmodule : phsr_cfg
`default_nettype wire

>>> rtl/phsr_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phsr_engine: byte engine with input and result registers
// Matches or inserts the header for the held byte and loads the result stage.
// ----------------------------------------------------------------------------
module phsr_engine (
  input  wire                             clk,
  input  wire                             rst,
  input  wire  phsr_pkg::cfg_t            cfg,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [phsr_pkg::BYTE_W-1:0]     data_byte,
  input  wire                             end_of_packet,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [phsr_pkg::BYTE_W-1:0]     out_byte,
  output logic                            byte_present,
  output logic                            last_of_packet,
  output logic [phsr_pkg::ERR_W-1:0]      error_code
);
  import phsr_pkg::*;

  // Input register.
  logic              held;
  logic [BYTE_W-1:0] held_byte;
  logic              held_eop;

  // Packet state.
  logic [LEN_W-1:0]  byte_position;
  logic              discarding;
  logic [SLOT_W-1:0] hdr_index;

  logic [LEN_W-1:0]  byte_position_next;
  logic              discarding_next;
  logic [SLOT_W-1:0] hdr_index_next;

  logic              out_adv;
  logic              inserting;
  logic              emit;
  logic              consume;
  logic [BYTE_W-1:0] r_byte;
  logic              r_present;
  logic              r_last;
  logic [ERR_W-1:0]  r_err;
  logic [BYTE_W-1:0] exp_byte;
  logic [LEN_W-1:0]  pos_inc;
  logic              bad;

  assign out_adv   = !out_valid || out_ready;
  assign inserting = held && (cfg.direction == DIR_RESTORE) && (cfg.length != '0) &&
                     (byte_position == '0);
  assign exp_byte  = cfg.header[{byte_position[SLOT_W-1:0], 3'b000} +: BYTE_W];
  assign pos_inc   = byte_position + LEN_W'(1);
  assign bad       = discarding || (held_byte != exp_byte);

  always_comb begin
    emit               = 1'b0;
    r_byte             = held_byte;
    r_present          = 1'b1;
    r_last             = held_eop;
    r_err              = ERR_NONE;
    byte_position_next = byte_position;
    discarding_next    = discarding;
    hdr_index_next     = hdr_index;

    if (inserting) begin
      // One header byte per cycle if not stalled; held byte waits for the last.
      emit   = 1'b1;
      r_byte = cfg.header[{hdr_index, 3'b000} +: BYTE_W];
      r_last = 1'b0;
      if ({1'b0, hdr_index} == LEN_W'(cfg.length - LEN_W'(1))) begin
        hdr_index_next     = '0;
        byte_position_next = cfg.length;
      end else begin
        hdr_index_next = hdr_index + SLOT_W'(1);
      end
    end else if (cfg.length == '0 || cfg.direction == DIR_RESTORE ||
                 byte_position >= cfg.length) begin
      emit = !(cfg.direction == DIR_STRIP && cfg.length != '0 && discarding);
      if (held_eop) begin
        byte_position_next = '0;
        discarding_next    = 1'b0;
      end
    end else begin
      r_byte    = '0;
      r_present = 1'b0;
      r_last    = 1'b1;
      if (pos_inc == cfg.length) begin
        if (bad) begin
          emit  = 1'b1;
          r_err = ERR_MISMATCH;
        end else begin
          emit = held_eop;
        end
        if (held_eop) begin
          byte_position_next = '0;
          discarding_next    = 1'b0;
        end else begin
          byte_position_next = cfg.length;
          discarding_next    = bad;
        end
      end else if (held_eop) begin
        emit               = 1'b1;
        r_err              = ERR_TOO_SHORT;
        byte_position_next = '0;
        discarding_next    = 1'b0;
      end else begin
        byte_position_next = pos_inc;
        discarding_next    = bad;
      end
    end
  end

  // A byte that gives no result may leave even while the result stage stalls.
  assign consume  = held && !inserting && (emit ? out_adv : 1'b1);
  assign in_ready = !held || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= 1'b0;
      out_valid     <= 1'b0;
      byte_position <= '0;
      discarding    <= 1'b0;
      hdr_index     <= '0;
    end else begin
      if (in_ready) begin
        held <= in_valid;
      end
      if (held && (consume || (inserting && out_adv))) begin
        byte_position <= byte_position_next;
        discarding    <= discarding_next;
        hdr_index     <= hdr_index_next;
      end
      if (out_adv) begin
        out_valid <= held && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      held_byte <= data_byte;
      held_eop  <= end_of_packet;
    end
    if (out_adv && held && emit) begin
      out_byte       <= r_byte;
      byte_present   <= r_present;
      last_of_packet <= r_last;
      error_code     <= r_err;
    end
  end

endmodule : phsr_engine
`default_nettype wire

>>> rtl/packet_header_strip_and_restore_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_header_strip_and_restore_core: packet header strip and restore
// Removes a configured packet header in strip mode or inserts it in restore
// mode, on a byte stream with an end-of-packet mark.
// ----------------------------------------------------------------------------
// The core takes one byte transaction per cycle unless out_ready holds it
// off, and returns results through a registered output stage, so a new byte
// is accepted while a result waits. In strip mode the header bytes of each
// packet give no results, a mismatch gives a single error result at the end
// of the header span and the rest of the packet is dropped, and a packet that
// ends inside the header gives a single too-short error. In restore mode the
// first byte of each packet is preceded by the clamped header_length header
// bytes, one per cycle while the result stage is not stalled. The rate is set
// by the single result register, which carries one result per cycle while
// out_ready is high. Configuration is written through its own port, which is
// always ready, and must only be changed while no packet is in flight.
// ----------------------------------------------------------------------------
module packet_header_strip_and_restore_core #(
  parameter int MAX_HEADER_BYTES = phsr_pkg::MAX_HEADER_BYTES_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // Configuration write channel.
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [phsr_pkg::CFG_IX_W-1:0]   cfg_index,
  input  wire  [phsr_pkg::HDR_W-1:0]      cfg_data,
  // Input byte channel.
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [phsr_pkg::BYTE_W-1:0]     data_byte,
  input  wire                             end_of_packet,
  // Result channel.
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [phsr_pkg::BYTE_W-1:0]     out_byte,
  output logic                            byte_present,
  output logic                            last_of_packet,
  output logic [phsr_pkg::ERR_W-1:0]      error_code
);
  import phsr_pkg::*;

  cfg_t cfg;

  // Register writes complete in the cycle they are presented.
  assign cfg_ready = 1'b1;

  phsr_cfg #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The engine holds one byte, walks the header span and owns the result stage.
  phsr_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_packet  (end_of_packet),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_present   (byte_present),
    .last_of_packet (last_of_packet),
    .error_code     (error_code)
  );

endmodule : packet_header_strip_and_restore_core
`default_nettype wire

>>> tb/sv/tb_packet_header_strip_and_restore_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_header_strip_and_restore_core: self-checking bench for the core
// Feeds byte packets in strip, restore and pass-through settings. Each
// accepted byte is run through a local model of the header logic, and every
// result the core returns is compared field by field with the oldest
// predicted one. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_packet_header_strip_and_restore_core;
  import phsr_pkg::*;

  localparam int MAX_HDR = MAX_HEADER_BYTES_DEF;
  // Index outside the register map. Writes to it must change nothing.
  localparam logic [CFG_IX_W-1:0] REG_SPARE = 2'd3;
  // Quiet cycles after the last predicted result. This covers a full restore
  // burst plus the output register, so a header byte that produces no result
  // has surely left the core before the configuration changes.
  localparam int QUIET_CYCLES = 2 * (MAX_HDR + 1) + 8;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              present;
    logic              last;
    logic [ERR_W-1:0]  err;
  } result_t;

  // Header engine model plus the queue of results still owed by the core.
  class strip_restore_scoreboard;
    logic             dir;
    logic [LEN_W-1:0] hdr_len;
    logic [HDR_W-1:0] hdr;
    logic [LEN_W-1:0] pos;
    logic             dropping;
    result_t          owed_results[$];
    int               failures;

    function new();
      dir      = DIR_STRIP;
      hdr_len  = '0;
      hdr      = '0;
      pos      = '0;
      dropping = 1'b0;
      failures = 0;
    endfunction

    function void set_reg(logic [CFG_IX_W-1:0] ix, logic [HDR_W-1:0] value);
      case (ix)
        REG_DIRECTION:     dir = value[0];
        REG_HEADER_LENGTH: hdr_len = value[LEN_W-1:0];
        REG_HEADER_BYTES:  hdr = value;
        default: ;
      endcase
    endfunction

    function void add_result(logic [BYTE_W-1:0] d, logic p, logic l, logic [ERR_W-1:0] e);
      result_t r;
      r.data    = d;
      r.present = p;
      r.last    = l;
      r.err     = e;
      owed_results.push_back(r);
    endfunction

    function void close_packet();
      pos      = '0;
      dropping = 1'b0;
    endfunction

    // Works out the results one accepted byte transaction gives.
    function void note_byte(logic [BYTE_W-1:0] b, logic eop);
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] nxt;
      logic             bad;
      len = (hdr_len > MAX_HDR) ? LEN_W'(MAX_HDR) : hdr_len;
      if (len == 0) begin
        add_result(b, 1'b1, eop, ERR_NONE);
        if (eop) close_packet();
        return;
      end
      if (dir == DIR_RESTORE) begin
        if (pos == 0) begin
          for (int k = 0; k < len; k++) add_result(hdr[8*k +: 8], 1'b1, 1'b0, ERR_NONE);
          pos = len;
        end
        add_result(b, 1'b1, eop, ERR_NONE);
        if (eop) close_packet();
        return;
      end
      if (pos >= len) begin
        if (!dropping) add_result(b, 1'b1, eop, ERR_NONE);
        if (eop) close_packet();
        return;
      end
      bad = dropping || (b != hdr[8*pos +: 8]);
      nxt = pos + 1'b1;
      if (nxt == len) begin
        if (bad) add_result('0, 1'b0, 1'b1, ERR_MISMATCH);
        else if (eop) add_result('0, 1'b0, 1'b1, ERR_NONE);
        if (eop) close_packet();
        else begin
          pos      = len;
          dropping = bad;
        end
      end else if (eop) begin
        add_result('0, 1'b0, 1'b1, ERR_TOO_SHORT);
        close_packet();
      end else begin
        pos      = nxt;
        dropping = bad;
      end
    endfunction

    function void check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [BYTE_W-1:0] d, logic p, logic l, logic [ERR_W-1:0] e);
      result_t w;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: out_byte=0x%0h byte_present=%b last=%b error=%0d",
               d, p, l, e);
        failures++;
        return;
      end
      w = owed_results.pop_front();
      check_field("out_byte", w.data, d);
      check_field("byte_present", 8'(w.present), 8'(p));
      check_field("last_of_packet", 8'(w.last), 8'(l));
      check_field("error_code", 8'(w.err), 8'(e));
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IX_W-1:0] cfg_index;
  logic [HDR_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_packet;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_present;
  logic              last_of_packet;
  logic [ERR_W-1:0]  error_code;

  strip_restore_scoreboard sb;
  idle_t idle_mode = IDLE_NONE;
  // Set by the stimulus to make the receiver start its long hold-off.
  bit    hold_request = 1'b0;

  packet_header_strip_and_restore_core DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_packet  (end_of_packet),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_present   (byte_present),
    .last_of_packet (last_of_packet),
    .error_code     (error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Percent of cycles in which the sender sits idle, per idling phase.
  function automatic int gap_pct();
    case (idle_mode)
      IDLE_SENDER: return 71;
      IDLE_BOTH:   return 33;
      default:     return 0;
    endcase
  endfunction

  // Percent of cycles in which the receiver stalls, per idling phase.
  function automatic int stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 71;
      IDLE_BOTH:     return 33;
      default:       return 0;
    endcase
  endfunction

  // Receiver. All signals are read right after the edge, so they hold their
  // values from before it, which is exactly what the core saw at that edge.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(out_byte, byte_present, last_of_packet, error_code);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        // Long hold-off: the sender keeps offering bytes, so the core fills
        // up and has to stall its input.
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct());
      end
    end
  end

  // Watchdog. A hang anywhere ends the run as a failure.
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_packet_header_strip_and_restore_core NOT OK");
        $finish;
      end
    end
  end

  // Offers one byte and returns at the edge where the transaction happens.
  // Valid is left high so the next call can keep it up without a glitch; the
  // caller or a later gap lowers it.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eop);
    while ($urandom_range(99) < gap_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_packet <= eop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, eop);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] pkt[$]);
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Register write. Valid stays up for back-to-back writes; the caller drops
  // it after the last one.
  task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [HDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(ix, value);
  endtask

  // Writes all three registers. Unused upper bits of the direction and
  // length writes carry random junk, which the core has to ignore.
  task automatic apply_config(input logic dir, input logic [LEN_W-1:0] len,
                              input logic [HDR_W-1:0] hdr);
    logic [HDR_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_DIRECTION, {junk[HDR_W-1:1], dir});
    junk = {$urandom, $urandom};
    write_reg(REG_HEADER_LENGTH, {junk[HDR_W-1:LEN_W], len});
    write_reg(REG_HEADER_BYTES, hdr);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering bytes until every predicted result has come back. Always
  // advances at least one edge, so valid is never dropped and raised in the
  // same step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.owed() != 0);
  endtask

  task automatic settle();
    wait_for_results();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // One random phase: a configuration, an idling pattern, and about n bytes.
  // In strip mode most packets start with the real header so that the
  // payload path is exercised; the rest carry a corrupted header, end inside
  // the header, or are plain noise.
  task automatic run_phase(input logic dir, input logic [LEN_W-1:0] len,
                           input logic [HDR_W-1:0] hdr, input idle_t mode,
                           input int n, input bit long_hold);
    logic [BYTE_W-1:0] pkt[$];
    int sent;
    int eff;
    int kind;
    int k;
    int cut;
    bit paused;
    settle();
    apply_config(dir, len, hdr);
    idle_mode = mode;
    if (long_hold) hold_request = 1'b1;
    eff    = (len > MAX_HDR) ? MAX_HDR : int'(len);
    sent   = 0;
    paused = 1'b0;
    while (sent < n) begin
      pkt.delete();
      kind = $urandom_range(99);
      if (dir == DIR_STRIP && eff > 0 && kind < 88) begin
        for (k = 0; k < eff; k++) pkt.push_back(hdr[8*k +: 8]);
        if (kind >= 70 && kind < 84) begin
          k = $urandom_range(eff - 1);
          pkt[k] = pkt[k] ^ 8'($urandom_range(255, 1));
        end
        if (kind >= 80 && eff > 1) begin
          // Packet ends inside the header span.
          cut = $urandom_range(eff - 1, 1);
          while (pkt.size() > cut) void'(pkt.pop_back());
        end else begin
          repeat ($urandom_range(5)) pkt.push_back(8'($urandom));
        end
      end else begin
        repeat (($urandom_range(9) == 0) ? $urandom_range(16, 1) : $urandom_range(6, 1))
          pkt.push_back(8'($urandom));
      end
      send_packet(pkt);
      sent += pkt.size();
      // Once per phase the sender waits for the core to run completely dry.
      if (!paused && sent >= n / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] pkt[$];
    sb = new();
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_DIRECTION;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    data_byte     <= '0;
    end_of_packet <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset the length is zero, so bytes pass straight through.
    pkt = '{8'h00};
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);

    // Strip a three-byte 00 00 01 header. A write to the spare index goes in
    // first and must leave the registers alone.
    settle();
    write_reg(REG_SPARE, '1);
    apply_config(DIR_STRIP, 4'd3, 64'hffff_ffff_ff01_0000);
    // Packet that is exactly the header: one empty last result.
    pkt = '{8'h00, 8'h00, 8'h01};
    send_packet(pkt);
    // Header followed by payload: only the payload comes out.
    pkt = '{8'h00, 8'h00, 8'h01, 8'ha5, 8'h5a};
    send_packet(pkt);
    // Wrong second byte: one mismatch error, and the payload is dropped.
    pkt = '{8'h00, 8'hff, 8'h01, 8'h33};
    send_packet(pkt);
    // Ends inside the header: too-short error.
    pkt = '{8'h00, 8'h00};
    send_packet(pkt);
    // Ends inside the header after a bad byte: still the too-short error.
    pkt = '{8'h07, 8'h00};
    send_packet(pkt);

    // Restore with a length above the bound, which acts as eight bytes. A
    // one-byte packet gives the full nine results.
    settle();
    apply_config(DIR_RESTORE, 4'd15, 64'hfedc_ba98_7654_3210);
    send_byte(8'h5a, 1'b1);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h3c, 1'b1);

    // Length shortened in the middle of a packet: the two header bytes
    // already seen now count as the whole header, so the rest passes.
    settle();
    apply_config(DIR_STRIP, 4'd4, 64'h0000_0000_4433_2211);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    settle();
    write_reg(REG_HEADER_LENGTH, 64'd2);
    cfg_valid <= 1'b0;
    send_byte(8'h81, 1'b0);
    send_byte(8'h7e, 1'b1);

    // Random phases over several settings and every idling pattern. The
    // restore phase with no random stalls also gets the long receiver hold.
    run_phase(DIR_STRIP,   4'd1,  {$urandom, $urandom}, IDLE_NONE,     40, 1'b0);
    run_phase(DIR_STRIP,   4'd8,  {$urandom, $urandom}, IDLE_SENDER,   40, 1'b0);
    run_phase(DIR_RESTORE, 4'd8,  {$urandom, $urandom}, IDLE_NONE,     40, 1'b1);
    run_phase(DIR_STRIP,   4'd15, {$urandom, $urandom}, IDLE_RECEIVER, 40, 1'b0);
    run_phase(DIR_RESTORE, 4'd1,  {$urandom, $urandom}, IDLE_BOTH,     40, 1'b0);
    run_phase(DIR_STRIP,   4'd0,  {$urandom, $urandom}, IDLE_RECEIVER, 32, 1'b0);
    run_phase(DIR_STRIP,   4'($urandom_range(7, 2)), {$urandom, $urandom}, IDLE_BOTH,
              40, 1'b0);
    run_phase(DIR_RESTORE, 4'($urandom_range(15)), {$urandom, $urandom}, IDLE_SENDER,
              32, 1'b0);
    run_phase(DIR_STRIP,   4'd8,  '1,                  IDLE_NONE,     16, 1'b0);
    run_phase(DIR_RESTORE, 4'd8,  '0,                  IDLE_BOTH,     16, 1'b0);

    // Everything sent: let the last results drain, then give the verdict.
    settle();
    if (sb.failures == 0) begin
      $display("tb_packet_header_strip_and_restore_core OK");
    end else begin
      $display("tb_packet_header_strip_and_restore_core NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/phsr_pkg.sv
rtl/phsr_cfg.sv
rtl/phsr_engine.sv
rtl/packet_header_strip_and_restore_core.sv
tb/sv/tb_packet_header_strip_and_restore_core.sv
